### rtl/stt_pkg.sv
// Shared types, constants and codes for the sparse triplet table.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int DIM_W    = 17;
    localparam int INDEX_W  = 16;
    localparam int VALUE_W  = 32;
    localparam int ENTRY_W  = 2 * INDEX_W + VALUE_W;
    localparam int KEY_W    = 2 * INDEX_W;

    localparam logic [COUNT_W-1:0] CAPACITY_COUNT = COUNT_W'(CAPACITY);

    // Request operations
    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_ZERO  = 2'd2;
    localparam logic [1:0] STATUS_FULL  = 2'd3;

    // Register select (word address bit of the configuration port)
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] row_count;
        logic [DIM_W-1:0] column_count;
    } cfg_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [1:0]                status;
    } result_t;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] data;
    } ram_wr_t;

endpackage

`default_nettype wire

### rtl/stt_cfg_regs.sv
// Configuration registers (row and column dimensions) behind the APB-style port.
// Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_cfg_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic      [31:0]   prdata,
    output logic               pready,
    output stt_pkg::cfg_t      cfg
);

    logic [stt_pkg::DIM_W-1:0] row_count_reg;
    logic [stt_pkg::DIM_W-1:0] column_count_reg;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= '0;
            column_count_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                stt_pkg::REG_ROW_COUNT:    row_count_reg    <= pwdata[stt_pkg::DIM_W-1:0];
                stt_pkg::REG_COLUMN_COUNT: column_count_reg <= pwdata[stt_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            stt_pkg::REG_ROW_COUNT:
                prdata = {{(32 - stt_pkg::DIM_W){1'b0}}, row_count_reg};
            stt_pkg::REG_COLUMN_COUNT:
                prdata = {{(32 - stt_pkg::DIM_W){1'b0}}, column_count_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.row_count    = row_count_reg;
    assign cfg.column_count = column_count_reg;

endmodule

`default_nettype wire

### rtl/stt_entry_ram.sv
// Entry store: one write port, one read port with registered read data.
// Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_entry_ram (
    input  wire logic                        clk,
    input  wire stt_pkg::ram_wr_t            wr,
    input  wire logic                        rd_en,
    input  wire logic [stt_pkg::ADDR_W-1:0]  rd_addr,
    output logic      [stt_pkg::ENTRY_W-1:0] rd_data
);

    logic [stt_pkg::ENTRY_W-1:0] mem [0:stt_pkg::CAPACITY-1];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/stt_scanner.sv
// Request sequencer: checks, scans the entry store with one key comparator,
// then overwrites, appends, reads or reports a full table. Depends on stt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stt_scanner (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire stt_pkg::cfg_t                      cfg,
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire logic                               operation,
    input  wire logic        [stt_pkg::INDEX_W-1:0] row_index,
    input  wire logic        [stt_pkg::INDEX_W-1:0] column_index,
    input  wire logic signed [stt_pkg::VALUE_W-1:0] write_value,
    output logic                                    res_valid,
    output stt_pkg::result_t                        res,
    input  wire logic                               res_take,
    output logic                                    rd_en,
    output logic             [stt_pkg::ADDR_W-1:0]  rd_addr,
    input  wire logic        [stt_pkg::ENTRY_W-1:0] rd_data,
    output stt_pkg::ram_wr_t                        ram_wr
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SCAN    = 2'd1;
    localparam logic [1:0] S_RESOLVE = 2'd2;
    localparam logic [1:0] S_FINISH  = 2'd3;

    logic [1:0]                         state_reg, state_next;
    logic                               op_reg;
    logic [stt_pkg::INDEX_W-1:0]        row_reg;
    logic [stt_pkg::INDEX_W-1:0]        col_reg;
    logic [stt_pkg::VALUE_W-1:0]        val_reg;
    logic [stt_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [stt_pkg::COUNT_W-1:0]        issue_idx_reg, issue_idx_next;
    logic                               pending_reg, pending_next;
    logic [stt_pkg::ADDR_W-1:0]         pend_idx_reg;
    logic                               hit_reg, hit_next;
    logic [stt_pkg::ADDR_W-1:0]         hit_idx_reg;
    logic [stt_pkg::VALUE_W-1:0]        hit_val_reg;
    logic [stt_pkg::VALUE_W-1:0]        res_value_reg, res_value_next;
    logic [1:0]                         res_status_reg, res_status_next;

    logic accept;
    logic range_bad;
    logic zero_bad;
    logic key_match;
    logic issue_ok;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);

    assign range_bad = ({1'b0, row_index} >= cfg.row_count)
                    || ({1'b0, column_index} >= cfg.column_count);
    assign zero_bad  = (operation == stt_pkg::OP_SET) && (write_value == '0);

    // the shared comparator: stored key against the request coordinates
    assign key_match = pending_reg
                    && (rd_data[stt_pkg::ENTRY_W-1:stt_pkg::VALUE_W] == {row_reg, col_reg});
    assign issue_ok  = (issue_idx_reg < count_reg);

    assign rd_en   = (state_reg == S_SCAN) && !key_match && issue_ok;
    assign rd_addr = issue_idx_reg[stt_pkg::ADDR_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_idx_next  = issue_idx_reg;
        pending_next    = pending_reg;
        hit_next        = hit_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        ram_wr.en       = 1'b0;
        ram_wr.addr     = hit_idx_reg;
        ram_wr.data     = {row_reg, col_reg, val_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_value_next = '0;
                    issue_idx_next = '0;
                    pending_next   = 1'b0;
                    hit_next       = 1'b0;
                    if (range_bad)
                    begin
                        res_status_next = stt_pkg::STATUS_RANGE;
                        state_next      = S_FINISH;
                    end
                    else if (zero_bad)
                    begin
                        res_status_next = stt_pkg::STATUS_ZERO;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        res_status_next = stt_pkg::STATUS_OK;
                        state_next      = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (key_match)
                begin
                    hit_next     = 1'b1;
                    pending_next = 1'b0;
                    state_next   = S_RESOLVE;
                end
                else if (issue_ok)
                begin
                    pending_next   = 1'b1;
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
                else
                begin
                    pending_next = 1'b0;
                    state_next   = S_RESOLVE;
                end
            end

            S_RESOLVE:
            begin
                state_next = S_FINISH;
                if (op_reg == stt_pkg::OP_GET)
                begin
                    res_value_next = hit_reg ? hit_val_reg : '0;
                end
                else if (hit_reg)
                begin
                    ram_wr.en = 1'b1;
                end
                else if (count_reg == stt_pkg::CAPACITY_COUNT)
                begin
                    res_status_next = stt_pkg::STATUS_FULL;
                end
                else
                begin
                    ram_wr.en   = 1'b1;
                    ram_wr.addr = count_reg[stt_pkg::ADDR_W-1:0];
                    count_next  = count_reg + 1'b1;
                end
            end

            S_FINISH:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_idx_reg <= '0;
            pending_reg   <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_idx_reg <= issue_idx_next;
            pending_reg   <= pending_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        if (accept)
        begin
            op_reg  <= operation;
            row_reg <= row_index;
            col_reg <= column_index;
            val_reg <= write_value;
        end
        if (rd_en)
        begin
            pend_idx_reg <= rd_addr;
        end
        if (key_match && (state_reg == S_SCAN))
        begin
            hit_idx_reg <= pend_idx_reg;
            hit_val_reg <= rd_data[stt_pkg::VALUE_W-1:0];
        end
    end

    assign res_valid      = (state_reg == S_FINISH);
    assign res.read_value = $signed(res_value_reg);
    assign res.status     = res_status_reg;

endmodule

`default_nettype wire

### rtl/sparse_triplet_table_top.sv
// Top level of the sparse triplet table: configuration port, sequencer,
// entry store and result register. Depends on stt_pkg and all stt_* modules.
`timescale 1ns / 1ps
`default_nettype none

// Sparse matrix held as a list of (row, column, value) entries, up to
// stt_pkg::CAPACITY of them.
//
// Use: program row_count (byte address 0) and column_count (byte address 4)
// over the APB-style port while the block is idle. Then present requests on
// the req channel (operation, row_index, column_index, write_value); a
// request is taken at a clock edge with req_valid high and req_stall low.
// Each request yields one result (read_value, status) on the rsp channel,
// taken at an edge with rsp_valid high and rsp_stall low.
//
// Timing: one request at a time. An index or zero-value error skips the scan and
// goes straight to the sequencer's final state; any other request scans the
// stored entries with one comparator, one entry per cycle from the store's read
// port, ending early on a match. The result register lets the next request
// start while a result waits; a stalled result holds, and the sequencer holds
// in its final state until that register is free.
//
// Reset clears the dimensions and the entry count; no clearing pass is run,
// so the block takes requests from the first cycle after reset.

module sparse_triplet_table_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic        [2:0]                  paddr,
    input  wire logic        [31:0]                 pwdata,
    output logic             [31:0]                 prdata,
    output logic                                    pready,
    // request channel
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire logic                               operation,
    input  wire logic        [stt_pkg::INDEX_W-1:0] row_index,
    input  wire logic        [stt_pkg::INDEX_W-1:0] column_index,
    input  wire logic signed [stt_pkg::VALUE_W-1:0] write_value,
    // result channel
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output logic signed      [stt_pkg::VALUE_W-1:0] read_value,
    output logic             [1:0]                  status
);

    stt_pkg::cfg_t                cfg;
    stt_pkg::result_t             res;
    stt_pkg::ram_wr_t             ram_wr;
    logic                         res_valid;
    logic                         res_take;
    logic                         rd_en;
    logic [stt_pkg::ADDR_W-1:0]   rd_addr;
    logic [stt_pkg::ENTRY_W-1:0]  rd_data;

    logic                         rsp_valid_reg;
    logic signed [stt_pkg::VALUE_W-1:0] read_value_reg;
    logic [1:0]                   status_reg;

    stt_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stt_scanner u_scanner (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .operation    (operation),
        .row_index    (row_index),
        .column_index (column_index),
        .write_value  (write_value),
        .res_valid    (res_valid),
        .res          (res),
        .res_take     (res_take),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .ram_wr       (ram_wr)
    );

    stt_entry_ram u_entry_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Load the result register when it is empty or being emptied this cycle.
    assign res_take = res_valid && (!rsp_valid_reg || !rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            read_value_reg <= res.read_value;
            status_reg     <= res.status;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire
